// ===== src/lgps_pkg.sv =====
// Shared types, register codes and fixed-point helpers of the linear gradient shader.
package lgps_pkg;

  // Gradient parameter: 17 fraction bits, one is 2^17.
  localparam int          TFRAC = 17;
  localparam logic [17:0] TONE  = 18'h20000;

  // Field widths fixed by the stream format.
  localparam int COORD_W = 12;
  localparam int INDEX_W = 4;
  localparam int CHAN_W  = 16;
  localparam int OUT_W   = 8;

  // Tile modes; the unused code behaves as clamp.
  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_COEF_X      = 3'd0;
  localparam logic [2:0] REG_COEF_Y      = 3'd1;
  localparam logic [2:0] REG_COEF_OFFSET = 3'd2;
  localparam logic [2:0] REG_TILE_MODE   = 3'd3;
  localparam logic [2:0] REG_COLOR_COUNT = 3'd4;

  // Word kinds carried in tuser.
  localparam logic FUNC_SHADE = 1'b0;
  localparam logic FUNC_LOAD  = 1'b1;

  // Channel slots of a colour; alpha sits in the top bits of a table entry.
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int CH_ALPHA = 3;

  typedef logic [3:0][CHAN_W-1:0] color_t;
  typedef logic [3:0][OUT_W-1:0]  pixel_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    color_t             color;
  } load_t;

  typedef struct packed {
    logic valid;
    logic load;
  } meta_t;

  typedef struct packed {
    logic [31:0] coef_x;
    logic [31:0] coef_y;
    logic [31:0] coef_offset;
    logic [1:0]  tile_mode;
    logic [4:0]  color_count;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coef_x:      32'd0,
    coef_y:      32'd0,
    coef_offset: 32'd0,
    tile_mode:   TILE_CLAMP,
    color_count: 5'd2
  };

  // Rounding biases: (65535^2 - 1) / 2 and (65535 - 1) / 2.
  localparam logic [39:0] PM_BIAS = 40'd2147418112;
  localparam logic [23:0] A8_BIAS = 24'd32767;

  // floor(x / 65535), exact for x below 2^32 - 1.
  function automatic logic [16:0] div_m16(input logic [31:0] x);
    logic [32:0] s;
    s = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
    return s[32:16];
  endfunction

endpackage

// ===== src/lgps_cfg.sv =====
// Configuration register file of the linear gradient shader.
module lgps_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  logic [2:0]         wr_index_i,
  input  logic [31:0]        wr_data_i,
  output lgps_pkg::cfg_t     cfg_o
);

  lgps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lgps_pkg::CFG_RESET;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        lgps_pkg::REG_COEF_X:      cfg_q.coef_x      <= wr_data_i;
        lgps_pkg::REG_COEF_Y:      cfg_q.coef_y      <= wr_data_i;
        lgps_pkg::REG_COEF_OFFSET: cfg_q.coef_offset <= wr_data_i;
        lgps_pkg::REG_TILE_MODE:   cfg_q.tile_mode   <= wr_data_i[1:0];
        lgps_pkg::REG_COLOR_COUNT: cfg_q.color_count <= wr_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lgps_param.sv =====
// Gradient parameter pipeline: affine map, tiling and interval selection.
module lgps_param #(
  parameter int COORD_BITS = 12,
  parameter int MAX_COLORS = 16,
  localparam int NW = $clog2(MAX_COLORS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic                          func_i,
  input  logic [lgps_pkg::COORD_W-1:0]  px_i,
  input  logic [lgps_pkg::COORD_W-1:0]  py_i,
  input  lgps_pkg::load_t               load_i,
  input  lgps_pkg::cfg_t                cfg_i,
  output lgps_pkg::meta_t               meta_o,
  output logic [NW-1:0]                 idx_o,
  output logic [17:0]                   u_o,
  output lgps_pkg::load_t               load_o
);

  localparam int CW   = (COORD_BITS < lgps_pkg::COORD_W) ? COORD_BITS : lgps_pkg::COORD_W;
  localparam int MW   = CW + 2;         // signed width of 2*p + 1
  localparam int PW   = 32 + MW;        // coefficient times half-pixel centre
  localparam int TW   = PW + 2;         // sum of three terms
  localparam int TNW  = 18 + NW;
  localparam int NMAX = MAX_COLORS - 1;

  lgps_pkg::meta_t meta1_q, meta2_q, meta3_q, meta4_q, meta5_q;
  lgps_pkg::load_t ld1_q, ld2_q, ld3_q, ld4_q, ld5_q;

  logic signed [MW-1:0] sx, sy;
  logic signed [PW-1:0] prx_q, pry_q;
  logic signed [TW-1:0] t2_q;
  logic [17:0]          tt, mir, tt3_q;
  logic [TNW-1:0]       tn4_q;
  logic [NW-1:0]        n, idx_d, idx5_q;
  logic [NW:0]          ihi;
  logic [17:0]          u_d, u5_q;

  // Pixel centres doubled: 2*p + 1, exact in the 17-bit fraction.
  assign sx = $signed({1'b0, px_i[CW-1:0], 1'b1});
  assign sy = $signed({1'b0, py_i[CW-1:0], 1'b1});

  // Interval count minus one, with the count held to 1..MAX_COLORS.
  always_comb begin
    if (cfg_i.color_count == 5'd0) begin
      n = '0;
    end else if (int'(cfg_i.color_count) > MAX_COLORS) begin
      n = NW'(NMAX);
    end else begin
      n = NW'(cfg_i.color_count - 5'd1);
    end
  end

  // Fold t into [0, one].
  always_comb begin
    mir = t2_q[17:0];
    case (cfg_i.tile_mode)
      lgps_pkg::TILE_REPEAT: tt = {1'b0, t2_q[16:0]};
      lgps_pkg::TILE_MIRROR: tt = (mir > lgps_pkg::TONE) ? (18'd0 - mir) : mir;
      default: begin
        if (t2_q[TW-1]) begin
          tt = '0;
        end else if (t2_q[TW-2:18] != '0 || t2_q[17:0] > lgps_pkg::TONE) begin
          tt = lgps_pkg::TONE;
        end else begin
          tt = t2_q[17:0];
        end
      end
    endcase
  end

  // Split t*n into interval and weight; the top end takes the last interval at full weight.
  always_comb begin
    ihi = tn4_q[TNW-1:lgps_pkg::TFRAC];
    if (n == '0) begin
      idx_d = '0;
      u_d   = '0;
    end else if (ihi >= {1'b0, n}) begin
      idx_d = n - NW'(1);
      u_d   = lgps_pkg::TONE;
    end else begin
      idx_d = ihi[NW-1:0];
      u_d   = {1'b0, tn4_q[16:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta1_q <= '0;
      meta2_q <= '0;
      meta3_q <= '0;
      meta4_q <= '0;
      meta5_q <= '0;
    end else if (en_i) begin
      meta1_q <= '{valid: in_valid_i, load: (func_i == lgps_pkg::FUNC_LOAD)};
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
      meta4_q <= meta3_q;
      meta5_q <= meta4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prx_q  <= $signed(cfg_i.coef_x) * sx;
      pry_q  <= $signed(cfg_i.coef_y) * sy;
      t2_q   <= TW'(prx_q) + TW'(pry_q) + (TW'($signed(cfg_i.coef_offset)) <<< 1);
      tt3_q  <= tt;
      tn4_q  <= TNW'(tt3_q) * TNW'(n);
      idx5_q <= idx_d;
      u5_q   <= u_d;
      ld1_q  <= load_i;
      ld2_q  <= ld1_q;
      ld3_q  <= ld2_q;
      ld4_q  <= ld3_q;
      ld5_q  <= ld4_q;
    end
  end

  assign meta_o = meta5_q;
  assign idx_o  = idx5_q;
  assign u_o    = u5_q;
  assign load_o = ld5_q;

endmodule

// ===== src/lgps_table.sv =====
// Colour table memory and per-channel linear interpolation.
module lgps_table #(
  parameter int MAX_COLORS = 16,
  localparam int NW = $clog2(MAX_COLORS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lgps_pkg::meta_t   meta_i,
  input  logic [NW-1:0]     idx_i,
  input  logic [17:0]       u_i,
  input  lgps_pkg::load_t   load_i,
  output logic              valid_o,
  output lgps_pkg::color_t  color_o
);

  localparam int TD = (MAX_COLORS < 16) ? MAX_COLORS : 16;
  localparam int AW = $clog2(TD);

  lgps_pkg::color_t ram_q [TD];
  lgps_pkg::color_t lo6_q, hi6_q;
  logic [17:0]      u6_q;
  logic [3:0][33:0] ph7_q, pl7_q;
  logic [3:0][34:0] sum8;
  lgps_pkg::color_t c8_q;
  logic             v6_q, v7_q, v8_q;
  logic [NW-1:0]    idx_up;
  logic [AW-1:0]    lo_addr, hi_addr;

  assign idx_up  = idx_i + NW'(1);
  assign lo_addr = idx_i[AW-1:0];
  assign hi_addr = idx_up[AW-1:0];

  // Loads write in stream order, so a later shade sees them.
  always_ff @(posedge clk_i) begin
    if (en_i && meta_i.valid && meta_i.load && (int'(load_i.index) < MAX_COLORS)) begin
      ram_q[load_i.index[AW-1:0]] <= load_i.color;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum8[k] = 35'(ph7_q[k]) + 35'(pl7_q[k]) + 35'(lgps_pkg::TONE >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= meta_i.valid && !meta_i.load;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo6_q <= ram_q[lo_addr];
      // Zero weight on the upper entry: drop it, it may never have been written.
      hi6_q <= (u_i == '0) ? '0 : ram_q[hi_addr];
      u6_q  <= u_i;
      for (int k = 0; k < 4; k++) begin
        ph7_q[k] <= 34'(hi6_q[k]) * 34'(u6_q);
        pl7_q[k] <= 34'(lo6_q[k]) * 34'(lgps_pkg::TONE - u6_q);
        c8_q[k]  <= sum8[k][32:17];
      end
    end
  end

  assign valid_o = v8_q;
  assign color_o = c8_q;

endmodule

// ===== src/lgps_premul.sv =====
// Alpha premultiply and rounding of unorm16 channels to 8 bits.
module lgps_premul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lgps_pkg::color_t  color_i,
  output logic              valid_o,
  output lgps_pkg::pixel_t  pixel_o
);

  localparam int NC = lgps_pkg::CH_ALPHA;   // colour channels below alpha

  logic [NC-1:0][31:0] p9_q;
  logic [15:0]         a9_q;
  logic [NC-1:0][39:0] x10_q;
  logic [23:0]         xa10_q;
  logic [NC-1:0][31:0] hl;
  logic [NC-1:0][16:0] qh, qy;
  logic [16:0]         qa;
  logic [NC-1:0][24:0] y11_q;
  logic [7:0]          oa11_q;
  lgps_pkg::pixel_t    out12_q;
  logic                v9_q, v10_q, v11_q, v12_q;

  // x / 65535^2 as two exact steps of division by 65535.
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      hl[k] = 32'(x10_q[k][39:16]) + 32'(x10_q[k][15:0]);
      qh[k] = lgps_pkg::div_m16(hl[k]);
      qy[k] = lgps_pkg::div_m16(32'(y11_q[k]));
    end
    qa = lgps_pkg::div_m16(32'(xa10_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en_i) begin
      v9_q  <= valid_i;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a9_q   <= color_i[lgps_pkg::CH_ALPHA];
      xa10_q <= 24'(a9_q) * 24'd255 + lgps_pkg::A8_BIAS;
      oa11_q <= qa[7:0];
      out12_q[lgps_pkg::CH_ALPHA] <= oa11_q;
      for (int k = 0; k < NC; k++) begin
        p9_q[k]    <= 32'(color_i[k]) * 32'(color_i[lgps_pkg::CH_ALPHA]);
        x10_q[k]   <= 40'(p9_q[k]) * 40'd255 + lgps_pkg::PM_BIAS;
        y11_q[k]   <= 25'(x10_q[k][39:16]) + 25'(qh[k]);
        out12_q[k] <= qy[k][7:0];
      end
    end
  end

  assign valid_o = v12_q;
  assign pixel_o = out12_q;

endmodule

// ===== src/linear_gradient_pixel_shader.sv =====
// Top level of the linear gradient pixel shader with clamp, repeat and mirror tiling.
//
//  channel  | direction | words                              | handshake
//  ---------+-----------+------------------------------------+-------------------------
//  s_axis   | in        | shade pixel or load table entry    | tvalid / tready
//  m_axis   | out       | one premultiplied ARGB8 per shade  | tvalid / tready
//  cfg      | in        | register index + 32-bit data       | cfg_valid_i / cfg_ready_o
//
//  One word enters per clock unless a finished word waits on m_axis. A shade word passes
//  12 register stages (coefficient multiply, sum, tile, t*n, interval split, table read,
//  two interpolation, alpha multiply, scale by 255, two divide-by-65535) that all advance
//  on one enable, then shows up on m_axis. A load word produces nothing and writes the
//  table as it leaves stage 5. Reset clears the valid bits and configuration, not the
//  table. A stalled output holds every stage and the input, losing nothing.
module linear_gradient_pixel_shader #(
  parameter int COORD_BITS = 12,
  parameter int MAX_COLORS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] pixel_x, [23:12] pixel_y, [27:24] entry_index, [43:28] entry_alpha,
  // [59:44] entry_red, [75:60] entry_green, [91:76] entry_blue, [95:92] zero
  input  logic [95:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]  s_axis_tuser,
  // Stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_alpha, [15:8] out_red, [23:16] out_green, [31:24] out_blue
  output logic [31:0] m_axis_tdata,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NW = $clog2(MAX_COLORS);

  lgps_pkg::cfg_t   cfg;
  lgps_pkg::load_t  load_in, load5;
  lgps_pkg::meta_t  meta5;
  lgps_pkg::color_t color8;
  lgps_pkg::pixel_t pixel;
  logic [NW-1:0]    idx5;
  logic [17:0]      u5;
  logic             valid8;
  logic             adv;
  logic             in_fire;

  // Advance the whole pipeline unless a finished word is waiting downstream.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && adv;
  assign cfg_ready_o   = 1'b1;

  // Unpack a load word into a table entry; alpha goes to the top slot.
  assign load_in.index                    = s_axis_tdata[27:24];
  assign load_in.color[lgps_pkg::CH_ALPHA] = s_axis_tdata[43:28];
  assign load_in.color[lgps_pkg::CH_RED]   = s_axis_tdata[59:44];
  assign load_in.color[lgps_pkg::CH_GREEN] = s_axis_tdata[75:60];
  assign load_in.color[lgps_pkg::CH_BLUE]  = s_axis_tdata[91:76];

  lgps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stages 1-5: t = cx*(2x+1) + cy*(2y+1) + 2*offset, tile, pick interval.
  lgps_param #(
    .COORD_BITS (COORD_BITS),
    .MAX_COLORS (MAX_COLORS)
  ) u_param (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (in_fire),
    .func_i     (s_axis_tuser[0]),
    .px_i       (s_axis_tdata[11:0]),
    .py_i       (s_axis_tdata[23:12]),
    .load_i     (load_in),
    .cfg_i      (cfg),
    .meta_o     (meta5),
    .idx_o      (idx5),
    .u_o        (u5),
    .load_o     (load5)
  );

  // Stages 6-8: table write or two-entry read, then interpolate and round.
  lgps_table #(
    .MAX_COLORS (MAX_COLORS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .meta_i  (meta5),
    .idx_i   (idx5),
    .u_i     (u5),
    .load_i  (load5),
    .valid_o (valid8),
    .color_o (color8)
  );

  // Stages 9-12: premultiply and round to 8 bits; stage 12 is the output register.
  lgps_premul u_premul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (valid8),
    .color_i (color8),
    .valid_o (m_axis_tvalid),
    .pixel_o (pixel)
  );

  assign m_axis_tdata = {pixel[lgps_pkg::CH_BLUE], pixel[lgps_pkg::CH_GREEN],
                         pixel[lgps_pkg::CH_RED], pixel[lgps_pkg::CH_ALPHA]};

endmodule
